[sv/parallel_port_registers_assert.svh]
// ----------------------------------------------------------------------------
// Parallel port registers assertion macros
// Shared concurrent assertion forms for the parallel port register block.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_PORT_REGISTERS_ASSERT_SVH
`define PARALLEL_PORT_REGISTERS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("parallel_port_registers: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("parallel_port_registers: next-cycle check failed");

`endif

[sv/ppr_pkg.sv]
// ----------------------------------------------------------------------------
// Parallel port registers package
// Commands, register indexes, bit masks and reset values of the SPP ports.
// ----------------------------------------------------------------------------
package ppr_pkg;

   // Number of ports decoded and ticked (1 to 3)
   localparam int PortCount = 3;
   localparam int PortMax   = 3;
   localparam int PortIdxW  = 2;

   localparam int AddrW   = 16;
   localparam int ByteW   = 8;
   localparam int CountW  = 16;
   localparam int CmdW    = 2;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 16;

   // Transaction commands
   localparam logic [CmdW-1:0] CmdRead  = 2'd0;
   localparam logic [CmdW-1:0] CmdWrite = 2'd1;
   localparam logic [CmdW-1:0] CmdTick  = 2'd2;

   // Register offsets within a port window
   localparam logic [1:0] OffData    = 2'd0;
   localparam logic [1:0] OffStatus  = 2'd1;
   localparam logic [1:0] OffControl = 2'd2;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CsrBaseFirst   = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrBaseSecond  = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrBaseThird   = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrTicksFirst  = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrTicksSecond = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrTicksThird  = 3'd5;
   localparam logic [CsrIdxW-1:0] CsrEnableMask  = 3'd6;

   // Status and control bits, Centronics polarity
   localparam logic [ByteW-1:0] StatNotIrq    = 8'h04;
   localparam logic [ByteW-1:0] StatNotAck    = 8'h40;
   localparam logic [ByteW-1:0] StatBusy      = 8'h80;
   localparam logic [ByteW-1:0] StatInv       = 8'h80;
   localparam logic [ByteW-1:0] CtrlNotStrobe = 8'h01;
   localparam logic [ByteW-1:0] CtrlNotSelect = 8'h08;
   localparam logic [ByteW-1:0] CtrlInv       = 8'h0B;
   localparam logic [ByteW-1:0] StatReset     = 8'h5C;
   localparam logic [ByteW-1:0] CtrlReset     = 8'h07;
   localparam logic [ByteW-1:0] NoDecodeByte  = 8'hFF;

   // Legacy base addresses
   localparam logic [AddrW-1:0] BaseResetFirst  = 16'h0378;
   localparam logic [AddrW-1:0] BaseResetSecond = 16'h0278;
   localparam logic [AddrW-1:0] BaseResetThird  = 16'h03BC;

   typedef logic [AddrW-1:0]  addr_type;
   typedef logic [ByteW-1:0]  byte_type;
   typedef logic [CountW-1:0] count_type;

endpackage

[sv/parallel_port_registers.sv]
// ----------------------------------------------------------------------------
// Parallel port registers
// Register model of up to three PC parallel printer ports on an I/O bus.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one bus transaction: a byte read, a byte write or a timer
//   tick. rsp_* returns exactly one result per transaction, in order: read
//   data, the byte handed to the printer on a strobe, and a mask of ports
//   whose idle countdown expired on a tick.
//   Both channels use valid/stall; a transaction moves on an edge where
//   valid is high and stall is low.
//   csr_* writes the base addresses, idle tick counts and the enable mask;
//   write it only while no transaction is in flight.
//   A transaction accepted into the input register passes through the
//   decode and port update logic into the result register that drives
//   rsp_*. Throughput: one transaction per cycle while rsp_stall is low;
//   the combinational decode and port update logic loads the result register.
//   When the receiver stalls, the result register holds, the input register
//   takes one more transaction, and then req_stall rises.
//   Synchronous reset restores the legacy base addresses, disables all
//   ports and returns every port's latches to their power-on values.
// ----------------------------------------------------------------------------
`include "parallel_port_registers_assert.svh"

module parallel_port_registers (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ppr_pkg::CmdW-1:0]          req_command,
   input  logic [ppr_pkg::AddrW-1:0]         req_port_address,
   input  logic [ppr_pkg::ByteW-1:0]         req_write_data,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ppr_pkg::ByteW-1:0]         rsp_read_data,
   output logic                              rsp_byte_sent,
   output logic [ppr_pkg::ByteW-1:0]         rsp_sent_byte,
   output logic [ppr_pkg::PortIdxW-1:0]      rsp_sent_port,
   output logic [ppr_pkg::PortMax-1:0]       rsp_timeout_mask,
   // Configuration write port
   input  logic                              csr_write_enable,
   input  logic [ppr_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [ppr_pkg::CsrW-1:0]          csr_write_data
);

   // Configuration registers
   ppr_pkg::addr_type  base_addr_ff  [ppr_pkg::PortMax];
   ppr_pkg::count_type idle_ticks_ff [ppr_pkg::PortMax];
   logic [ppr_pkg::PortMax-1:0] enable_mask_ff;

   // Per-port state and its next value
   ppr_pkg::byte_type  data_latch_ff     [ppr_pkg::PortMax];
   ppr_pkg::byte_type  status_bits_ff    [ppr_pkg::PortMax];
   ppr_pkg::byte_type  control_bits_ff   [ppr_pkg::PortMax];
   ppr_pkg::count_type idle_countdown_ff [ppr_pkg::PortMax];
   ppr_pkg::byte_type  data_latch_in     [ppr_pkg::PortMax];
   ppr_pkg::byte_type  status_bits_in    [ppr_pkg::PortMax];
   ppr_pkg::byte_type  control_bits_in   [ppr_pkg::PortMax];
   ppr_pkg::count_type idle_countdown_in [ppr_pkg::PortMax];

   // Input register
   logic                          s1_valid_ff, s1_valid_in;
   logic [ppr_pkg::CmdW-1:0]      s1_command_ff;
   ppr_pkg::addr_type             s1_address_ff;
   ppr_pkg::byte_type             s1_wdata_ff;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   ppr_pkg::byte_type             rsp_read_data_ff, rsp_read_data_in;
   logic                          rsp_byte_sent_ff, rsp_byte_sent_in;
   ppr_pkg::byte_type             rsp_sent_byte_ff, rsp_sent_byte_in;
   logic [ppr_pkg::PortIdxW-1:0]  rsp_sent_port_ff, rsp_sent_port_in;
   logic [ppr_pkg::PortMax-1:0]   rsp_timeout_mask_ff, rsp_timeout_mask_in;

   logic                          req_accept;
   logic                          s1_advance;

   // Address decode
   logic                          hit;
   logic [ppr_pkg::PortIdxW-1:0]  hit_port;
   logic [1:0]                    hit_offset;
   ppr_pkg::byte_type             ctrl_new;

   // ------------------------------------------------------------------------
   // Handshake: the input register moves on whenever the result register is
   // empty or its transaction is being taken this cycle.
   // ------------------------------------------------------------------------
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Decode: scan from the highest port down so the lowest enabled port
   // whose three-byte window holds the address wins. The window top is
   // compared at 17 bits so it never wraps past 0xFFFF.
   // ------------------------------------------------------------------------
   always_comb begin
      hit        = 1'b0;
      hit_port   = '0;
      hit_offset = ppr_pkg::OffData;
      for (int p = ppr_pkg::PortCount - 1; p >= 0; p--) begin
         if (enable_mask_ff[p] && (base_addr_ff[p] != '0) &&
             (s1_address_ff >= base_addr_ff[p]) &&
             ({1'b0, s1_address_ff} <= ({1'b0, base_addr_ff[p]} + 17'd2))) begin
            hit        = 1'b1;
            hit_port   = ppr_pkg::PortIdxW'(p);
            hit_offset = 2'(s1_address_ff - base_addr_ff[p]);
         end
      end
   end

   // Control write arrives in host polarity; flip into Centronics polarity
   assign ctrl_new = s1_wdata_ff ^ ppr_pkg::CtrlInv;

   // ------------------------------------------------------------------------
   // Port update and result for the transaction in the input register.
   // State only changes when the transaction advances into the result
   // register, so a stalled transaction is not applied twice.
   // ------------------------------------------------------------------------
   always_comb begin
      data_latch_in     = data_latch_ff;
      status_bits_in    = status_bits_ff;
      control_bits_in   = control_bits_ff;
      idle_countdown_in = idle_countdown_ff;

      rsp_read_data_in    = '0;
      rsp_byte_sent_in    = 1'b0;
      rsp_sent_byte_in    = '0;
      rsp_sent_port_in    = '0;
      rsp_timeout_mask_in = '0;

      unique case (s1_command_ff)
         ppr_pkg::CmdRead: begin
            if (!hit) begin
               rsp_read_data_in = ppr_pkg::NoDecodeByte;
            end else begin
               unique case (hit_offset)
                  ppr_pkg::OffData: begin
                     rsp_read_data_in = data_latch_ff[hit_port];
                  end
                  ppr_pkg::OffStatus: begin
                     // Reading status acknowledges: drop BUSY, release ACK and IRQ
                     rsp_read_data_in = status_bits_ff[hit_port] ^ ppr_pkg::StatInv;
                     status_bits_in[hit_port] =
                        (status_bits_ff[hit_port] | ppr_pkg::StatNotAck |
                         ppr_pkg::StatNotIrq) & ~ppr_pkg::StatBusy;
                  end
                  default: begin
                     rsp_read_data_in = control_bits_ff[hit_port] ^ ppr_pkg::CtrlInv;
                  end
               endcase
            end
         end
         ppr_pkg::CmdWrite: begin
            if (hit && (hit_offset == ppr_pkg::OffData)) begin
               data_latch_in[hit_port] = s1_wdata_ff;
            end else if (hit && (hit_offset == ppr_pkg::OffControl)) begin
               // Strobe rising while select is asserted hands the byte over
               if (((control_bits_ff[hit_port] &
                     (ppr_pkg::CtrlNotStrobe | ppr_pkg::CtrlNotSelect)) == '0) &&
                   ((ctrl_new & ppr_pkg::CtrlNotStrobe) != '0)) begin
                  rsp_byte_sent_in            = 1'b1;
                  rsp_sent_byte_in            = data_latch_ff[hit_port];
                  rsp_sent_port_in            = hit_port;
                  idle_countdown_in[hit_port] = idle_ticks_ff[hit_port];
                  status_bits_in[hit_port] =
                     (status_bits_ff[hit_port] & ~ppr_pkg::StatNotAck) |
                     ppr_pkg::StatBusy;
               end
               control_bits_in[hit_port] = ctrl_new;
            end
         end
         ppr_pkg::CmdTick: begin
            // Count down every running timer, enabled or not
            for (int p = 0; p < ppr_pkg::PortCount; p++) begin
               if (idle_countdown_ff[p] != '0) begin
                  idle_countdown_in[p] = idle_countdown_ff[p] - 1'b1;
                  if (idle_countdown_ff[p] == ppr_pkg::CountW'(1)) begin
                     rsp_timeout_mask_in[p] = 1'b1;
                  end
               end
            end
         end
         default: begin
            // Unused command: no state change, all-zero result
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         base_addr_ff[0] <= ppr_pkg::BaseResetFirst;
         base_addr_ff[1] <= ppr_pkg::BaseResetSecond;
         base_addr_ff[2] <= ppr_pkg::BaseResetThird;
         for (int p = 0; p < ppr_pkg::PortMax; p++) begin
            idle_ticks_ff[p] <= '0;
         end
         enable_mask_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ppr_pkg::CsrBaseFirst:   base_addr_ff[0]  <= csr_write_data;
            ppr_pkg::CsrBaseSecond:  base_addr_ff[1]  <= csr_write_data;
            ppr_pkg::CsrBaseThird:   base_addr_ff[2]  <= csr_write_data;
            ppr_pkg::CsrTicksFirst:  idle_ticks_ff[0] <= csr_write_data;
            ppr_pkg::CsrTicksSecond: idle_ticks_ff[1] <= csr_write_data;
            ppr_pkg::CsrTicksThird:  idle_ticks_ff[2] <= csr_write_data;
            ppr_pkg::CsrEnableMask:
               enable_mask_ff <= csr_write_data[ppr_pkg::PortMax-1:0];
            default: begin
               // Drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < ppr_pkg::PortMax; p++) begin
            data_latch_ff[p]     <= '0;
            status_bits_ff[p]    <= ppr_pkg::StatReset;
            control_bits_ff[p]   <= ppr_pkg::CtrlReset;
            idle_countdown_ff[p] <= '0;
         end
      end else if (s1_advance) begin
         data_latch_ff     <= data_latch_in;
         status_bits_ff    <= status_bits_in;
         control_bits_ff   <= control_bits_in;
         idle_countdown_ff <= idle_countdown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: input capture on accept, result capture on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_command_ff <= req_command;
         s1_address_ff <= req_port_address;
         s1_wdata_ff   <= req_write_data;
      end
      if (s1_advance) begin
         rsp_read_data_ff    <= rsp_read_data_in;
         rsp_byte_sent_ff    <= rsp_byte_sent_in;
         rsp_sent_byte_ff    <= rsp_sent_byte_in;
         rsp_sent_port_ff    <= rsp_sent_port_in;
         rsp_timeout_mask_ff <= rsp_timeout_mask_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_byte_sent    = rsp_byte_sent_ff;
   assign rsp_sent_byte    = rsp_sent_byte_ff;
   assign rsp_sent_port    = rsp_sent_port_ff;
   assign rsp_timeout_mask = rsp_timeout_mask_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // Stall the requester only while the input register is occupied
   `PPR_ASSERT_IMPL(a_stall_needs_s1, clock, reset, req_stall, s1_valid_ff)
   // A transaction that advances always lands in the result register
   `PPR_ASSERT_NEXT(a_advance_lands, clock, reset, s1_advance, rsp_valid_ff)
   // A strobe result never carries a tick timeout
   `PPR_ASSERT_IMPL(a_sent_no_timeout, clock, reset, rsp_valid_ff && rsp_byte_sent_ff,
                    rsp_timeout_mask_ff == '0)
   // Sent byte and port are zero when no byte went out
   `PPR_ASSERT_IMPL(a_unsent_zero, clock, reset, rsp_valid_ff && !rsp_byte_sent_ff,
                    (rsp_sent_byte_ff == '0) && (rsp_sent_port_ff == '0))

endmodule
